@@ hw/rtl/sorted_key_list_table_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted key list table assertion macros
// Shared property wrappers for the assertions of the table logic.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_LIST_TABLE_DEFINES_SVH
`define SORTED_KEY_LIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define SKLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key list table check failed");
`define SKLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key list table check failed");
`else
`define SKLT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SKLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/sklt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key list table package
// Field widths, operation and status codes shared by the table modules.
// ----------------------------------------------------------------------------
package sklt_pkg;

    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 64;
    localparam int POS_W     = 6;
    localparam int WHERE_W   = 7;
    localparam int ENTRY_W   = KEY_W + PAYLOAD_W;

    localparam int S_DATA_W  = 104;
    localparam int M_DATA_W  = 112;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_APPEND = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/sklt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key list table entry memory
// One write port and one registered read port holding key and payload.
// ----------------------------------------------------------------------------
module sklt_ram #(
    parameter int DEPTH = 64
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  sklt_pkg::entry_t          wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output sklt_pkg::entry_t          rdata
);
    import sklt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_key_list_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_list_table_defines.svh"
// ----------------------------------------------------------------------------
// Sorted key list table
// Ordered table of signed keys with payloads, searched and shifted in place.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY entries in one single-port-write memory and
// handles one word at a time. An insert or delete walks the table one entry a
// cycle, comparing each stored key with the request key, then moves the tail
// one entry a cycle through the memory's one read and one write port. An
// insert or append on a full table and a read out of range go straight to
// the reply. A new word is taken once the previous one has been handed to the
// output register, so a stalled output holds the block until that word is
// taken.
module sorted_key_list_table #(
    parameter int CAPACITY = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // key, payload, position (from bit 0 up)
    input  wire  [sklt_pkg::S_DATA_W-1:0]    s_tdata,
    // operation
    input  wire  [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // where, entry_count, read_key, read_payload (from bit 0 up)
    output logic [sklt_pkg::M_DATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                       m_tuser
);
    import sklt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_SHIFT_UP = 8'b0000_0100,
        S_SHIFT_DN = 8'b0000_1000,
        S_PLACE    = 8'b0001_0000,
        S_READ     = 8'b0010_0000,
        S_RDATA    = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        at_reg, at_next;
    logic                 pend_reg, pend_next;
    logic [CW-1:0]        dst_reg, dst_next;
    status_t              status_reg, status_next;
    entry_t               res_reg, res_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata;
    logic [AW-1:0]        ram_raddr;
    entry_t               ram_rdata;

    logic                 s_accept;
    logic [KEY_W-1:0]     in_key;
    logic [PAYLOAD_W-1:0] in_payload;
    logic [POS_W-1:0]     in_pos;
    logic [KEY_W-1:0]     rd_key;
    logic                 key_ge;
    logic                 match;
    logic                 moving;
    logic                 err_fields_zero;

    sklt_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign in_key     = s_tdata[KEY_W-1:0];
    assign in_payload = s_tdata[KEY_W+PAYLOAD_W-1:KEY_W];
    assign in_pos     = s_tdata[ENTRY_W+POS_W-1:ENTRY_W];

    // The key compares of the block: a signed order test for inserts, equality for deletes.
    assign rd_key = ram_rdata[KEY_W-1:0];
    assign key_ge = !($signed(rd_key) < $signed(key_reg));
    assign match  = pend_reg && ((op_reg == OP_INSERT) ? key_ge : (rd_key == key_reg));

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        payload_next  = payload_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        at_next       = at_reg;
        pend_next     = 1'b0;
        dst_next      = dst_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_waddr     = dst_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next      = op_t'(s_tuser);
                    key_next     = in_key;
                    payload_next = in_payload;
                    pos_next     = in_pos;
                    status_next  = ST_OK;
                    res_next     = '0;
                    at_next      = '0;
                    ptr_next     = '0;
                    case (op_t'(s_tuser))
                        OP_INSERT: begin
                            if (count_reg == CAP_C) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_DELETE: begin
                            state_next = S_SCAN;
                        end
                        OP_APPEND: begin
                            if (count_reg == CAP_C) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                at_next    = count_reg;
                                state_next = S_PLACE;
                            end
                        end
                        default: begin
                            if (XW'(in_pos) >= XW'(count_reg)) begin
                                status_next = ST_RANGE;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (ptr_reg < count_reg) begin
                    pend_next = 1'b1;
                    dst_next  = ptr_reg;
                    ptr_next  = ptr_reg + 1'b1;
                end
                if (match) begin
                    at_next   = dst_reg;
                    pend_next = 1'b0;
                    if (op_reg == OP_INSERT) begin
                        ptr_next   = count_reg;
                        state_next = S_SHIFT_UP;
                    end else begin
                        ptr_next   = dst_reg + 1'b1;
                        state_next = S_SHIFT_DN;
                    end
                end else if (!pend_reg && (ptr_reg >= count_reg)) begin
                    if (op_reg == OP_INSERT) begin
                        at_next    = count_reg;
                        ptr_next   = count_reg;
                        state_next = S_SHIFT_UP;
                    end else begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
            end
            S_SHIFT_UP: begin
                ram_raddr = AW'(ptr_reg - 1'b1);
                if (ptr_reg > at_reg) begin
                    pend_next = 1'b1;
                    dst_next  = ptr_reg;
                    ptr_next  = ptr_reg - 1'b1;
                end
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (!pend_reg && (ptr_reg == at_reg)) begin
                    state_next = S_PLACE;
                end
            end
            S_SHIFT_DN: begin
                if (ptr_reg < count_reg) begin
                    pend_next = 1'b1;
                    dst_next  = ptr_reg - 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (!pend_reg && (ptr_reg >= count_reg)) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = at_reg[AW-1:0];
                ram_wdata  = {payload_reg, key_reg};
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_READ: begin
                ram_raddr  = AW'(pos_reg);
                state_next = S_RDATA;
            end
            S_RDATA: begin
                res_next   = ram_rdata;
                at_next    = CW'(pos_reg);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {2'b00, res_reg[ENTRY_W-1:KEY_W], res_reg[KEY_W-1:0],
                                     WHERE_W'(count_reg),
                                     (status_reg == ST_OK) ? WHERE_W'(at_reg) : '0};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        key_reg     <= key_next;
        payload_reg <= payload_next;
        pos_reg     <= pos_next;
        ptr_reg     <= ptr_next;
        at_reg      <= at_next;
        dst_reg     <= dst_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign moving = (state_reg == S_SHIFT_UP) || (state_reg == S_SHIFT_DN) ||
                    (state_reg == S_PLACE);
    assign err_fields_zero = (m_tdata[6:0] == '0) && (m_tdata[109:14] == '0);

    `SKLT_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CAP_C)
    `SKLT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready)
    `SKLT_ASSERT_SAME(a_write_when_moving, aclk, aresetn, ram_we, moving)
    `SKLT_ASSERT_SAME(a_error_zero_data, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), err_fields_zero)

endmodule

`default_nettype wire

@@ bench/sklt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key list table checker
// Watches both stream channels, keeps its own copy of the ordered table,
// predicts the reply to every accepted request word and compares each reply
// word field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sklt_checker #(
    parameter int CAPACITY = 64
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    input  wire                            s_tready,
    input  wire  [sklt_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire  [1:0]                     s_tuser,
    input  wire                            m_tvalid,
    input  wire                            m_tready,
    input  wire  [sklt_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire  [1:0]                     m_tuser,
    output int                             fail_count,
    output int                             pending,
    output int                             ok_hits,
    output int                             full_hits,
    output int                             missing_hits,
    output int                             range_hits,
    output int                             peak_count
);
    import sklt_pkg::*;

    typedef struct {
        status_t                status;
        logic [WHERE_W-1:0]     where;
        logic [WHERE_W-1:0]     count;
        logic [KEY_W-1:0]       rkey;
        logic [PAYLOAD_W-1:0]   rpay;
    } table_reply_t;

    logic signed [KEY_W-1:0] table_keys [CAPACITY];
    logic [PAYLOAD_W-1:0]    table_payloads [CAPACITY];
    int                      held;
    table_reply_t            awaited_replies [$];
    table_reply_t            want;
    table_reply_t            got;

    function automatic table_reply_t table_apply(op_t op, logic signed [KEY_W-1:0] k,
                                                 logic [PAYLOAD_W-1:0] p, int pos);
        table_reply_t r;
        int           i;
        int           j;
        r.status = ST_OK;
        r.where  = '0;
        r.rkey   = '0;
        r.rpay   = '0;
        case (op)
            OP_INSERT, OP_APPEND: begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    i = 0;
                    if (op == OP_APPEND) begin
                        i = held;
                    end else begin
                        while (i < held && table_keys[i] < k) i++;
                    end
                    for (j = held; j > i; j--) begin
                        table_keys[j]     = table_keys[j-1];
                        table_payloads[j] = table_payloads[j-1];
                    end
                    table_keys[i]     = k;
                    table_payloads[i] = p;
                    held++;
                    r.where = WHERE_W'(i);
                end
            end
            OP_DELETE: begin
                i = 0;
                while (i < held && table_keys[i] != k) i++;
                if (i >= held) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (j = i; j + 1 < held; j++) begin
                        table_keys[j]     = table_keys[j+1];
                        table_payloads[j] = table_payloads[j+1];
                    end
                    held--;
                    r.where = WHERE_W'(i);
                end
            end
            default: begin
                if (pos >= held) begin
                    r.status = ST_RANGE;
                end else begin
                    r.where = WHERE_W'(pos);
                    r.rkey  = table_keys[pos];
                    r.rpay  = table_payloads[pos];
                end
            end
        endcase
        r.count = WHERE_W'(held);
        return r;
    endfunction

    task automatic check_field(string name, logic [PAYLOAD_W-1:0] exp_val,
                               logic [PAYLOAD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("reply field %s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held         = 0;
            fail_count   = 0;
            pending      = 0;
            ok_hits      = 0;
            full_hits    = 0;
            missing_hits = 0;
            range_hits   = 0;
            peak_count   = 0;
            awaited_replies.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                want = table_apply(op_t'(s_tuser), s_tdata[0 +: KEY_W],
                                   s_tdata[KEY_W +: PAYLOAD_W],
                                   int'(s_tdata[KEY_W+PAYLOAD_W +: POS_W]));
                awaited_replies.push_back(want);
                case (want.status)
                    ST_OK:        ok_hits++;
                    ST_FULL:      full_hits++;
                    ST_NOT_FOUND: missing_hits++;
                    default:      range_hits++;
                endcase
                if (held > peak_count) peak_count = held;
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.where  = m_tdata[0 +: WHERE_W];
                got.count  = m_tdata[WHERE_W +: WHERE_W];
                got.rkey   = m_tdata[2*WHERE_W +: KEY_W];
                got.rpay   = m_tdata[2*WHERE_W+KEY_W +: PAYLOAD_W];
                if (awaited_replies.size() == 0) begin
                    $error("reply word arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("where", want.where, got.where);
                    check_field("entry_count", want.count, got.count);
                    check_field("read_key", want.rkey, got.rkey);
                    check_field("read_payload", want.rpay, got.rpay);
                end
            end
            pending = awaited_replies.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key list table testbench
// Drives table requests in bursts with random gaps, stalls the reply stream
// in changing patterns, and leaves prediction and comparison to the checker.
// A short directed sequence comes first, then phases that grow the table toward
// full, drain it toward empty, or mix all operations over a small key set.
// ----------------------------------------------------------------------------
module tb_top;
    import sklt_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_WORDS = 1950;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_GROW   = 0;
    localparam int PHASE_SHRINK = 1;
    localparam int PHASE_MIX    = 2;
    localparam int READY_ALWAYS = 0;
    localparam int READY_RANDOM = 1;
    localparam int READY_SPARSE = 2;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    int fail_count;
    int pending;
    int ok_hits;
    int full_hits;
    int missing_hits;
    int range_hits;
    int peak_count;

    int cycle_count = 0;
    int burst_left  = 0;
    int ready_mode  = READY_ALWAYS;
    int ready_left  = 0;
    int words_sent  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    sorted_key_list_table #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sklt_checker #(
        .CAPACITY (CAPACITY)
    ) table_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .ok_hits      (ok_hits),
        .full_hits    (full_hits),
        .missing_hits (missing_hits),
        .range_hits   (range_hits),
        .peak_count   (peak_count)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sorted_key_list_table");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (ready_left == 0) begin
                ready_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
                ready_left = $urandom_range(20, 300);
            end
            ready_left--;
            case (ready_mode)
                READY_ALWAYS: m_tready = 1'b1;
                READY_RANDOM: m_tready = 1'($urandom_range(0, 1));
                default:      m_tready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic send_word(op_t op, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p,
                             logic [POS_W-1:0] pos);
        int gap;
        s_tdata  = {{(S_DATA_W-KEY_W-PAYLOAD_W-POS_W){1'b0}}, pos, p, k};
        s_tuser  = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Keys mostly come from a small set with the extremes in it, so that
    // duplicates and successful deletes are frequent.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        idx = $urandom_range(0, 15);
        if (sel < 60) begin
            case (idx)
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return idx * 37 - 300;
            endcase
        end else if (sel < 80) begin
            return $urandom;
        end
        return $urandom_range(0, 100) - 50;
    endfunction

    function automatic op_t pick_op(int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PHASE_GROW:   return (r < 45) ? OP_INSERT : (r < 80) ? OP_APPEND :
                                 (r < 95) ? OP_READ : OP_DELETE;
            PHASE_SHRINK: return (r < 75) ? OP_DELETE : (r < 90) ? OP_READ :
                                 (r < 95) ? OP_INSERT : OP_APPEND;
            default:      return op_t'(r % 4);
        endcase
    endfunction

    initial begin
        int phase;
        int phase_len;
        int i;
        logic [POS_W-1:0] pos;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_word(OP_READ,   32'h0,         64'h0,                   6'd0);
        send_word(OP_DELETE, 32'h0,         64'h0,                   6'd0);
        send_word(OP_INSERT, 32'd5,         64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send_word(OP_INSERT, -32'sd5,       64'h0,                   6'd0);
        send_word(OP_INSERT, 32'd5,         64'hAAAA_AAAA_AAAA_AAAA, 6'd0);
        send_word(OP_INSERT, 32'h7FFF_FFFF, 64'h5555_5555_5555_5555, 6'd0);
        send_word(OP_INSERT, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 6'd0);
        send_word(OP_INSERT, 32'h0,         64'hFEDC_BA98_7654_3210, 6'd0);
        send_word(OP_APPEND, 32'h0,         64'h8000_0000_0000_0001, 6'd0);
        send_word(OP_APPEND, 32'hFFFF_FFFF, 64'h1,                   6'd0);
        send_word(OP_READ,   32'h0,         64'h0,                   6'd0);
        send_word(OP_READ,   32'h0,         64'h0,                   6'd1);
        send_word(OP_READ,   32'h0,         64'h0,                   6'd3);
        send_word(OP_READ,   32'h0,         64'h0,                   6'd7);
        send_word(OP_READ,   32'h0,         64'h0,                   6'd8);
        send_word(OP_READ,   32'h0,         64'h0,                   6'd63);
        send_word(OP_DELETE, 32'd5,         64'h0,                   6'd0);
        send_word(OP_DELETE, 32'd42,        64'h0,                   6'd0);
        send_word(OP_DELETE, 32'h8000_0000, 64'h0,                   6'd0);
        send_word(OP_DELETE, 32'hFFFF_FFFF, 64'h0,                   6'd0);
        send_word(OP_DELETE, 32'h7FFF_FFFF, 64'h0,                   6'd0);
        send_word(OP_READ,   32'h0,         64'h0,                   6'd2);

        // The first phase is a grow phase, long enough for the table to hit full.
        phase     = PHASE_GROW;
        phase_len = 140;
        i         = 0;
        while (i < RANDOM_WORDS) begin
            if (phase_len > RANDOM_WORDS - i) phase_len = RANDOM_WORDS - i;
            repeat (phase_len) begin
                pos = ($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, 63))
                                                  : POS_W'($urandom_range(0, 7));
                send_word(pick_op(phase), pick_key(), {$urandom, $urandom}, pos);
                i++;
            end
            phase     = $urandom_range(PHASE_GROW, PHASE_MIX);
            phase_len = $urandom_range(40, 160);
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d request words: %0d ok, %0d table full, %0d key not found,",
                 words_sent, ok_hits, full_hits, missing_hits);
        $display("%0d out of range; the table held at most %0d of %0d entries.",
                 range_hits, peak_count, CAPACITY);
        if (fail_count == 0) begin
            $display("PASS sorted_key_list_table");
        end else begin
            $display("FAIL sorted_key_list_table");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sklt_pkg.sv
hw/rtl/sklt_ram.sv
hw/rtl/sorted_key_list_table.sv
bench/sklt_checker.sv
bench/tb_top.sv
